FILE: rtl/hscu_pkg.sv
// Package for the handheld sound control unit.
// Holds operation codes, register numbers, control byte slots and small helper functions.
// No dependencies.
package hscu_pkg;

  // Operations of one input item.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_SEQ   = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Register numbers as seen on the bus.
  localparam logic [4:0] REG_NR10  = 5'd0;
  localparam logic [4:0] REG_NR11  = 5'd1;
  localparam logic [4:0] REG_NR12  = 5'd2;
  localparam logic [4:0] REG_NR13  = 5'd3;
  localparam logic [4:0] REG_NR14  = 5'd4;
  localparam logic [4:0] REG_NR21  = 5'd6;
  localparam logic [4:0] REG_NR22  = 5'd7;
  localparam logic [4:0] REG_NR23  = 5'd8;
  localparam logic [4:0] REG_NR24  = 5'd9;
  localparam logic [4:0] REG_NR30  = 5'd10;
  localparam logic [4:0] REG_NR31  = 5'd11;
  localparam logic [4:0] REG_NR32  = 5'd12;
  localparam logic [4:0] REG_NR33  = 5'd13;
  localparam logic [4:0] REG_NR34  = 5'd14;
  localparam logic [4:0] REG_NR41  = 5'd16;
  localparam logic [4:0] REG_NR42  = 5'd17;
  localparam logic [4:0] REG_NR43  = 5'd18;
  localparam logic [4:0] REG_NR44  = 5'd19;
  localparam logic [4:0] REG_NR50  = 5'd20;
  localparam logic [4:0] REG_NR51  = 5'd21;
  localparam logic [4:0] REG_POWER = 5'd22;

  // Slots of the stored control bytes.
  localparam int NUM_CTL = 16;
  localparam logic [3:0] SLOT_NR10 = 4'd0;
  localparam logic [3:0] SLOT_NR11 = 4'd1;
  localparam logic [3:0] SLOT_NR12 = 4'd2;
  localparam logic [3:0] SLOT_NR14 = 4'd3;
  localparam logic [3:0] SLOT_NR21 = 4'd4;
  localparam logic [3:0] SLOT_NR22 = 4'd5;
  localparam logic [3:0] SLOT_NR24 = 4'd6;
  localparam logic [3:0] SLOT_NR30 = 4'd7;
  localparam logic [3:0] SLOT_NR32 = 4'd8;
  localparam logic [3:0] SLOT_NR33 = 4'd9;
  localparam logic [3:0] SLOT_NR34 = 4'd10;
  localparam logic [3:0] SLOT_NR42 = 4'd11;
  localparam logic [3:0] SLOT_NR43 = 4'd12;
  localparam logic [3:0] SLOT_NR44 = 4'd13;
  localparam logic [3:0] SLOT_NR50 = 4'd14;
  localparam logic [3:0] SLOT_NR51 = 4'd15;

  // Read masks of the partly readable registers.
  localparam logic [7:0] MASK_SWEEP = 8'h80;
  localparam logic [7:0] MASK_DUTY  = 8'h3F;
  localparam logic [7:0] MASK_CTL   = 8'hBF;
  localparam logic [7:0] MASK_DAC   = 8'h7F;
  localparam logic [7:0] MASK_LEVEL = 8'h9F;
  localparam logic [7:0] READ_OPEN  = 8'hFF;

  localparam logic [10:0] FREQ_MAX = 11'h7FF;

  // Length/envelope lanes: 0 is channel 1, 1 is channel 2, 2 is the noise channel.
  function automatic logic [3:0] env_slot(input int li);
    logic [3:0] s;
    s = (li == 0) ? SLOT_NR12 : ((li == 1) ? SLOT_NR22 : SLOT_NR42);
    return s;
  endfunction

  function automatic logic [3:0] ctl_slot(input int li);
    logic [3:0] s;
    s = (li == 0) ? SLOT_NR14 : ((li == 1) ? SLOT_NR24 : SLOT_NR44);
    return s;
  endfunction

  function automatic logic [4:0] hi_reg(input int li);
    logic [4:0] r;
    r = (li == 0) ? REG_NR14 : ((li == 1) ? REG_NR24 : REG_NR44);
    return r;
  endfunction

  function automatic logic [1:0] chan_of(input int li);
    logic [1:0] c;
    c = (li == 2) ? 2'd3 : 2'(li);
    return c;
  endfunction

  // Next frequency of the sweep unit, one bit wider to show overflow.
  function automatic logic [11:0] sweep_calc(input logic [10:0] shadow, input logic [7:0] s);
    logic [10:0] d;
    d = shadow >> s[2:0];
    return s[3] ? ({1'b0, shadow} - {1'b0, d}) : ({1'b0, shadow} + {1'b0, d});
  endfunction

  // Output bit of a square wave at a duty position.
  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
    logic [7:0] w;
    unique case (duty)
      2'd0: w = 8'h01;
      2'd1: w = 8'h81;
      2'd2: w = 8'h87;
      2'd3: w = 8'h7E;
    endcase
    return w[3'd7 - pos];
  endfunction

endpackage

FILE: rtl/hscu_if.sv
// Channel interfaces of the handheld sound control unit: input, result and configuration.
// Depends on nothing; payload widths are the fixed field widths.
interface hscu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [4:0] reg_index;
  logic [7:0] write_data;
  logic [5:0] tick_cycles;
  modport source (output valid, mode, reg_index, write_data, tick_cycles, input ready);
  modport sink (input valid, mode, reg_index, write_data, tick_cycles, output ready);
endinterface

interface hscu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] channel_status;
  logic [3:0] square1_level;
  logic [3:0] square2_level;
  logic [3:0] noise_level;
  modport source (output valid, read_data, channel_status, square1_level, square2_level,
                  noise_level, input ready);
  modport sink (input valid, read_data, channel_status, square1_level, square2_level,
                noise_level, output ready);
endinterface

interface hscu_cfg_if;
  logic valid;
  logic ready;
  logic cgb_mode;
  modport source (output valid, cgb_mode, input ready);
  modport sink (input valid, cgb_mode, output ready);
endinterface

FILE: rtl/hscu_square_timer.sv
// Period counter and duty position of one square channel.
// Depends on hscu_pkg.
module hscu_square_timer
  import hscu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [5:0]  cycles,
  input  logic [10:0] freq,
  input  logic        load,
  input  logic [10:0] load_freq,
  output logic [2:0]  duty_pos
);

  logic [13:0] count;
  logic [13:0] count_next;
  logic [2:0]  pos_next;
  logic [11:0] k;
  logic [13:0] period;
  logic [13:0] load_period;
  logic [5:0]  deficit;
  logic        wraps;
  logic [3:0]  q;
  logic [4:0]  n;
  logic [18:0] span;

  assign k           = 12'd2048 - {1'b0, freq};
  assign period      = {k, 2'b00};
  assign load_period = {12'd2048 - {1'b0, load_freq}, 2'b00};
  assign wraps       = (count <= {8'd0, cycles});
  assign deficit     = cycles - count[5:0];

  // Extra wraps when the period is shorter than the elapsed cycles.
  always_comb begin
    q = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if ((k < 12'd16) && ((8'(j) * {4'd0, k[3:0]}) <= {4'd0, deficit[5:2]})) begin
        q = q + 4'd1;
      end
    end
    n    = {1'b0, q} + 5'd1;
    span = 19'(n) * {5'd0, period};
  end

  // New count and duty position.
  always_comb begin
    count_next = count;
    pos_next   = duty_pos;
    if (load) begin
      count_next = load_period;
    end else if (advance) begin
      if (wraps) begin
        count_next = 14'(span - {13'd0, deficit});
        pos_next   = duty_pos + n[2:0];
      end else begin
        count_next = count - {8'd0, cycles};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      duty_pos <= '0;
    end else begin
      count    <= count_next;
      duty_pos <= pos_next;
    end
  end

endmodule

FILE: rtl/hscu_noise_timer.sv
// Period counter and shift register of the noise channel.
// Depends on hscu_pkg.
module hscu_noise_timer
  import hscu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [5:0] cycles,
  input  logic [7:0] poly,
  input  logic       load,
  output logic       lfsr_bit
);

  logic [21:0] count;
  logic [21:0] count_next;
  logic [15:0] shift;
  logic [15:0] shift_next;
  logic [6:0]  base;
  logic [21:0] period;
  logic [5:0]  deficit;
  logic        wraps;
  logic [2:0]  q;
  logic [3:0]  n;
  logic [25:0] span;
  logic        x;

  assign base     = (poly[2:0] != 3'd0) ? {poly[2:0], 4'd0} : 7'd8;
  assign period   = {15'd0, base} << poly[7:4];
  assign wraps    = (count <= {16'd0, cycles});
  assign deficit  = cycles - count[5:0];
  assign lfsr_bit = shift[0];

  // Extra shifts when the period is shorter than the elapsed cycles.
  always_comb begin
    q = 3'd0;
    for (int j = 1; j < 8; j++) begin
      if ((period[21:6] == 16'd0) && ((9'(j) * {3'd0, period[5:0]}) <= {3'd0, deficit})) begin
        q = q + 3'd1;
      end
    end
    n    = {1'b0, q} + 4'd1;
    span = 26'(n) * {4'd0, period};
  end

  // New count and shift register, up to eight shifts per transfer.
  always_comb begin
    count_next = count;
    shift_next = shift;
    x          = 1'b0;
    if (load) begin
      count_next = period;
      shift_next = 16'hFFFF;
    end else if (advance) begin
      if (wraps) begin
        count_next = 22'(span - {20'd0, deficit});
        for (int i = 0; i < 8; i++) begin
          if (4'(i) < n) begin
            x = shift_next[0] ^ shift_next[1];
            shift_next = {1'b0, x, shift_next[14:1]};
            if (poly[3]) begin
              shift_next[6] = x;
            end
          end
        end
      end else begin
        count_next = count - {16'd0, cycles};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      shift <= '0;
    end else begin
      count <= count_next;
      shift <= shift_next;
    end
  end

endmodule

FILE: rtl/handheld_sound_control_unit.sv
// Top level of the handheld sound control unit: register file, frame sequencer and levels.
// Depends on hscu_pkg, hscu_if, hscu_square_timer and hscu_noise_timer.
//
// Usage: each transfer on sound_in is one bus operation: a register write, a register
// read, one 512 Hz frame sequencer step, or a tick of up to 63 machine cycles.
// Every transfer gives exactly one result on sound_out, carrying the read byte (zero
// unless a read), the channel enables and the digital 0..15 levels of channels 1, 2, 4.
// The result is registered: it is valid in the cycle after the transfer.
// Throughput is one item per cycle while the receiver takes results; all work is done
// between the state registers and the result register.
// When the receiver stalls, the result holds and sound_in.ready falls until it is
// taken; a new item is accepted in the same cycle that a waiting result is taken.
// The cfg channel is always ready and sets cgb_mode; write it only while idle.
// Reset (synchronous) powers the unit down and clears every register and counter.
module handheld_sound_control_unit
  import hscu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  hscu_in_if.sink   sound_in,
  hscu_out_if.source sound_out,
  hscu_cfg_if.sink  cfg
);

  logic        cgb_mode;
  logic        power_on, power_on_next;
  logic [2:0]  seq_step, seq_step_next;
  logic [7:0]  ctl [NUM_CTL];
  logic [7:0]  ctl_next [NUM_CTL];
  logic [10:0] sq_freq [2];
  logic [10:0] sq_freq_next [2];
  logic [6:0]  len_s [3];
  logic [6:0]  len_s_next [3];
  logic [8:0]  len_w, len_w_next;
  logic [3:0]  ch_on, ch_on_next;
  logic [3:0]  sweep_count, sweep_count_next;
  logic        sweep_active, sweep_active_next;
  logic        neg_used, neg_used_next;
  logic [10:0] shadow, shadow_next;
  logic [3:0]  env_timer [3];
  logic [3:0]  env_timer_next [3];
  logic [3:0]  vol [3];
  logic [3:0]  vol_next [3];
  logic [7:0]  read_data, read_data_next;
  logic        out_valid;
  logic        in_xfer;
  logic        allowed;
  logic [7:0]  v;
  logic [4:0]  r;
  logic [1:0]  sq_load;
  logic        noise_load;
  logic        tick_en;
  logic [2:0]  duty_pos [2];
  logic        lfsr_bit;

  assign sound_in.ready = !out_valid || sound_out.ready;
  assign in_xfer        = sound_in.valid && sound_in.ready;
  assign v              = sound_in.write_data;
  assign r              = sound_in.reg_index;
  assign cfg.ready      = 1'b1;
  assign allowed        = power_on || (r == REG_NR11) || (r == REG_NR21) || (r == REG_NR31)
                          || (r == REG_NR41) || (r == REG_POWER);
  assign tick_en        = in_xfer && (sound_in.mode == MODE_TICK);

  // Trigger reloads of the channel timers.
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      sq_load[q] = in_xfer && (sound_in.mode == MODE_WRITE) && allowed
                   && (r == hi_reg(q)) && v[7];
    end
    noise_load = in_xfer && (sound_in.mode == MODE_WRITE) && allowed
                 && (r == REG_NR44) && v[7];
  end

  // Next state of registers, lengths, sweep and envelopes for one transfer.
  always_comb begin
    logic [7:0]  old_b;
    logic [7:0]  env_b;
    logic [7:0]  s_b;
    logic [2:0]  per;
    logic [11:0] f;
    old_b             = 8'd0;
    env_b             = 8'd0;
    f                 = 12'd0;
    power_on_next     = power_on;
    seq_step_next     = seq_step;
    ctl_next          = ctl;
    sq_freq_next      = sq_freq;
    len_s_next        = len_s;
    len_w_next        = len_w;
    ch_on_next        = ch_on;
    sweep_count_next  = sweep_count;
    sweep_active_next = sweep_active;
    neg_used_next     = neg_used;
    shadow_next       = shadow;
    env_timer_next    = env_timer;
    vol_next          = vol;
    read_data_next    = 8'd0;
    s_b               = ctl[SLOT_NR10];
    per               = s_b[6:4];
    if (in_xfer) begin
      unique case (sound_in.mode)
        MODE_WRITE: begin
          if (allowed) begin
            unique case (r)
              REG_NR10: begin
                ctl_next[SLOT_NR10] = v;
                if (!v[3] && neg_used) ch_on_next[0] = 1'b0;
              end
              REG_NR11: begin
                if (power_on) ctl_next[SLOT_NR11] = v & 8'hC0;
                len_s_next[0] = 7'd64 - {1'b0, v[5:0]};
              end
              REG_NR12: begin
                ctl_next[SLOT_NR12] = v;
                if (v[7:3] == 5'd0) ch_on_next[0] = 1'b0;
              end
              REG_NR13: sq_freq_next[0] = {sq_freq[0][10:8], v};
              REG_NR21: begin
                if (power_on) ctl_next[SLOT_NR21] = v & 8'hC0;
                len_s_next[1] = 7'd64 - {1'b0, v[5:0]};
              end
              REG_NR22: begin
                ctl_next[SLOT_NR22] = v;
                if (v[7:3] == 5'd0) ch_on_next[1] = 1'b0;
              end
              REG_NR23: sq_freq_next[1] = {sq_freq[1][10:8], v};
              REG_NR30: begin
                ctl_next[SLOT_NR30] = v;
                if (!v[7]) ch_on_next[2] = 1'b0;
              end
              REG_NR31: len_w_next = 9'd256 - {1'b0, v};
              REG_NR32: ctl_next[SLOT_NR32] = v;
              REG_NR33: ctl_next[SLOT_NR33] = v;
              REG_NR34: begin
                old_b = ctl[SLOT_NR34];
                ctl_next[SLOT_NR34] = v;
                if (seq_step[0] && !old_b[6] && v[6] && (len_w != 9'd0)) begin
                  len_w_next = len_w - 9'd1;
                  if ((len_w_next == 9'd0) && !v[7]) ch_on_next[2] = 1'b0;
                end
                if (v[7]) begin
                  if (seq_step[0] && v[6] && (len_w_next == 9'd0)) len_w_next = 9'd255;
                  if (len_w_next == 9'd0) len_w_next = 9'd256;
                  if (ctl[SLOT_NR30][7]) ch_on_next[2] = 1'b1;
                end
              end
              REG_NR41: len_s_next[2] = 7'd64 - {1'b0, v[5:0]};
              REG_NR42: begin
                ctl_next[SLOT_NR42] = v;
                if (v[7:3] == 5'd0) ch_on_next[3] = 1'b0;
              end
              REG_NR43: ctl_next[SLOT_NR43] = v;
              REG_NR50: ctl_next[SLOT_NR50] = v;
              REG_NR51: ctl_next[SLOT_NR51] = v;
              REG_POWER: begin
                power_on_next = v[7];
                if (!v[7]) begin
                  for (int i = 0; i < NUM_CTL; i++) ctl_next[i] = 8'd0;
                  sq_freq_next[0] = 11'd0;
                  sq_freq_next[1] = 11'd0;
                  ch_on_next      = 4'd0;
                  seq_step_next   = 3'd7;
                end
                if (!power_on && v[7]) begin
                  seq_step_next = 3'd0;
                  if (cgb_mode) begin
                    for (int li = 0; li < 3; li++) len_s_next[li] = 7'd64;
                    len_w_next = 9'd256;
                  end
                end
              end
              default: ;
            endcase
            // High byte writes of channels 1, 2 and 4: length edge and trigger.
            for (int li = 0; li < 3; li++) begin
              if (r == hi_reg(li)) begin
                old_b = ctl[ctl_slot(li)];
                env_b = ctl[env_slot(li)];
                ctl_next[ctl_slot(li)] = v;
                if (li < 2) sq_freq_next[li] = {v[2:0], sq_freq[li][7:0]};
                if (seq_step[0] && !old_b[6] && v[6] && (len_s[li] != 7'd0)) begin
                  len_s_next[li] = len_s[li] - 7'd1;
                  if (len_s_next[li] == 7'd0) ch_on_next[chan_of(li)] = 1'b0;
                end
                if (v[7]) begin
                  if (seq_step[0] && v[6] && (len_s_next[li] == 7'd0)) len_s_next[li] = 7'd63;
                  if (env_b[7:3] != 5'd0) ch_on_next[chan_of(li)] = 1'b1;
                  if (len_s_next[li] == 7'd0) len_s_next[li] = 7'd64;
                  env_timer_next[li] = (env_b[2:0] != 3'd0) ? {1'b0, env_b[2:0]} : 4'd8;
                  vol_next[li]       = env_b[7:4];
                  if (li == 0) begin
                    neg_used_next     = 1'b0;
                    sweep_active_next = (per != 3'd0) || (s_b[2:0] != 3'd0);
                    sweep_count_next  = (per != 3'd0) ? {1'b0, per} : 4'd8;
                    shadow_next       = sq_freq_next[0];
                    if (s_b[2:0] != 3'd0) begin
                      if (s_b[3]) neg_used_next = 1'b1;
                      f = sweep_calc(shadow_next, s_b);
                      if (f > {1'b0, FREQ_MAX}) ch_on_next[0] = 1'b0;
                    end
                  end
                end
              end
            end
          end
        end
        MODE_READ: begin
          unique case (r)
            REG_NR10:  read_data_next = ctl[SLOT_NR10] | MASK_SWEEP;
            REG_NR11:  read_data_next = ctl[SLOT_NR11] | MASK_DUTY;
            REG_NR12:  read_data_next = ctl[SLOT_NR12];
            REG_NR14:  read_data_next = ctl[SLOT_NR14] | MASK_CTL;
            REG_NR21:  read_data_next = ctl[SLOT_NR21] | MASK_DUTY;
            REG_NR22:  read_data_next = ctl[SLOT_NR22];
            REG_NR24:  read_data_next = ctl[SLOT_NR24] | MASK_CTL;
            REG_NR30:  read_data_next = ctl[SLOT_NR30] | MASK_DAC;
            REG_NR32:  read_data_next = ctl[SLOT_NR32] | MASK_LEVEL;
            REG_NR34:  read_data_next = ctl[SLOT_NR34] | MASK_CTL;
            REG_NR42:  read_data_next = ctl[SLOT_NR42];
            REG_NR43:  read_data_next = ctl[SLOT_NR43];
            REG_NR44:  read_data_next = ctl[SLOT_NR44] | MASK_CTL;
            REG_NR50:  read_data_next = ctl[SLOT_NR50];
            REG_NR51:  read_data_next = ctl[SLOT_NR51];
            REG_POWER: read_data_next = {power_on, 3'b111, ch_on};
            default:   read_data_next = READ_OPEN;
          endcase
        end
        MODE_SEQ: begin
          if (power_on) begin
            // Length counters on even steps.
            if (!seq_step[0]) begin
              for (int li = 0; li < 3; li++) begin
                if (ctl[ctl_slot(li)][6] && (len_s[li] != 7'd0)) begin
                  len_s_next[li] = len_s[li] - 7'd1;
                  if (len_s_next[li] == 7'd0) ch_on_next[chan_of(li)] = 1'b0;
                end
              end
              if (ctl[SLOT_NR34][6] && (len_w != 9'd0)) begin
                len_w_next = len_w - 9'd1;
                if (len_w_next == 9'd0) ch_on_next[2] = 1'b0;
              end
            end
            // Frequency sweep on steps 2 and 6.
            if ((seq_step == 3'd2) || (seq_step == 3'd6)) begin
              if (sweep_count != 4'd0) sweep_count_next = sweep_count - 4'd1;
              if (sweep_count_next == 4'd0) begin
                sweep_count_next = (per != 3'd0) ? {1'b0, per} : 4'd8;
                if (sweep_active && (per != 3'd0)) begin
                  if (s_b[3]) neg_used_next = 1'b1;
                  f = sweep_calc(shadow, s_b);
                  if (f > {1'b0, FREQ_MAX}) begin
                    ch_on_next[0] = 1'b0;
                  end else if (s_b[2:0] != 3'd0) begin
                    shadow_next     = f[10:0];
                    sq_freq_next[0] = f[10:0];
                  end
                  f = sweep_calc(shadow_next, s_b);
                  if (f > {1'b0, FREQ_MAX}) ch_on_next[0] = 1'b0;
                end
              end
            end
            // Volume envelopes on step 7.
            if (seq_step == 3'd7) begin
              for (int li = 0; li < 3; li++) begin
                env_b = ctl[env_slot(li)];
                if (env_b[2:0] != 3'd0) begin
                  if (env_timer[li] != 4'd0) env_timer_next[li] = env_timer[li] - 4'd1;
                  if (env_timer_next[li] == 4'd0) begin
                    env_timer_next[li] = {1'b0, env_b[2:0]};
                    if (env_b[3] && (vol[li] < 4'd15)) vol_next[li] = vol[li] + 4'd1;
                    else if (!env_b[3] && (vol[li] > 4'd0)) vol_next[li] = vol[li] - 4'd1;
                  end
                end
              end
            end
            seq_step_next = seq_step + 3'd1;
          end
        end
        MODE_TICK: ;
      endcase
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cgb_mode     <= 1'b0;
      power_on     <= 1'b0;
      seq_step     <= '0;
      for (int i = 0; i < NUM_CTL; i++) ctl[i] <= '0;
      for (int i = 0; i < 2; i++) sq_freq[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        len_s[i]     <= '0;
        env_timer[i] <= '0;
        vol[i]       <= '0;
      end
      len_w        <= '0;
      ch_on        <= '0;
      sweep_count  <= '0;
      sweep_active <= 1'b0;
      neg_used     <= 1'b0;
      shadow       <= '0;
      out_valid    <= 1'b0;
      read_data    <= '0;
    end else begin
      if (cfg.valid) cgb_mode <= cfg.cgb_mode;
      power_on     <= power_on_next;
      seq_step     <= seq_step_next;
      ctl          <= ctl_next;
      sq_freq      <= sq_freq_next;
      len_s        <= len_s_next;
      len_w        <= len_w_next;
      ch_on        <= ch_on_next;
      sweep_count  <= sweep_count_next;
      sweep_active <= sweep_active_next;
      neg_used     <= neg_used_next;
      shadow       <= shadow_next;
      env_timer    <= env_timer_next;
      vol          <= vol_next;
      if (in_xfer) begin
        out_valid <= 1'b1;
        read_data <= read_data_next;
      end else if (sound_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Channel timers.
  hscu_square_timer u_sq1 (
    .clk       (clk),
    .rst       (rst),
    .advance   (tick_en),
    .cycles    (sound_in.tick_cycles),
    .freq      (sq_freq[0]),
    .load      (sq_load[0]),
    .load_freq ({v[2:0], sq_freq[0][7:0]}),
    .duty_pos  (duty_pos[0])
  );

  hscu_square_timer u_sq2 (
    .clk       (clk),
    .rst       (rst),
    .advance   (tick_en),
    .cycles    (sound_in.tick_cycles),
    .freq      (sq_freq[1]),
    .load      (sq_load[1]),
    .load_freq ({v[2:0], sq_freq[1][7:0]}),
    .duty_pos  (duty_pos[1])
  );

  hscu_noise_timer u_noise (
    .clk      (clk),
    .rst      (rst),
    .advance  (tick_en),
    .cycles   (sound_in.tick_cycles),
    .poly     (ctl[SLOT_NR43]),
    .load     (noise_load),
    .lfsr_bit (lfsr_bit)
  );

  // Result fields; the state is stable while a result waits.
  assign sound_out.valid          = out_valid;
  assign sound_out.read_data      = read_data;
  assign sound_out.channel_status = ch_on;
  assign sound_out.square1_level  = (ch_on[0] && (ctl[SLOT_NR12][7:3] != 5'd0)
                                     && duty_bit(ctl[SLOT_NR11][7:6], duty_pos[0]))
                                    ? vol[0] : 4'd0;
  assign sound_out.square2_level  = (ch_on[1] && (ctl[SLOT_NR22][7:3] != 5'd0)
                                     && duty_bit(ctl[SLOT_NR21][7:6], duty_pos[1]))
                                    ? vol[1] : 4'd0;
  assign sound_out.noise_level    = (ch_on[3] && (ctl[SLOT_NR42][7:3] != 5'd0) && !lfsr_bit)
                                    ? vol[2] : 4'd0;

endmodule
